>>> rtl/ids_pkg.sv
// shared types and functions for the id string keyed hash block
// no dependencies; used by ids_front, ids_queue, ids_back and the top level

package ids_pkg;

  localparam int unsigned WordWidth = 32;
  localparam int unsigned ByteWidth = 8;

  // one finished message handed from front to back
  typedef struct packed {
    logic [WordWidth-1:0] rev;
    logic [WordWidth-1:0] fwd;
    logic [WordWidth-1:0] id;
  } job_t;

  // reorder the id bytes, replacing a zero byte 2 or 3 with the inverse of byte 1 or 0
  function automatic logic [WordWidth-1:0] mix_id(input logic [WordWidth-1:0] id);
    logic [ByteWidth-1:0] b0;
    logic [ByteWidth-1:0] b1;
    logic [ByteWidth-1:0] b2;
    logic [ByteWidth-1:0] b3;
    b0 = id[7:0];
    b1 = id[15:8];
    b2 = id[23:16];
    b3 = id[31:24];
    if (b2 == '0) b2 = ~b1;
    if (b3 == '0) b3 = ~b0;
    return {b0, b2, b1, b3};
  endfunction

endpackage

>>> rtl/ids_front.sv
// front end: takes message bytes and keeps the forward and reverse hashes
// depends on ids_pkg; hands one job per message to the job queue

module ids_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          data_byte,
  input  logic                byte_valid,
  input  logic signed [31:0]  message_id,
  input  logic                last,
  output logic                job_push,
  output ids_pkg::job_t       job
);

  logic [31:0] forward_acc;
  logic [31:0] reverse_acc;
  logic [31:0] reverse_weight;
  logic        index_odd;

  logic [31:0] forward_acc_next;
  logic [31:0] reverse_acc_next;
  logic [31:0] reverse_weight_next;
  logic [31:0] byte_ext;
  logic [31:0] fwd_shifted;
  logic [31:0] weight_shifted;
  logic [31:0] weighted_byte;

  // absorb one byte; the shifts alternate with index parity
  always_comb begin
    byte_ext       = {{24{data_byte[7]}}, data_byte};
    fwd_shifted    = index_odd ? (forward_acc << 4) : (forward_acc << 3);
    weight_shifted = index_odd ? (reverse_weight << 5) : (reverse_weight << 4);
    weighted_byte  = byte_ext * reverse_weight;
    if (byte_valid) begin
      forward_acc_next    = forward_acc + byte_ext + fwd_shifted;
      reverse_acc_next    = reverse_acc + weighted_byte;
      reverse_weight_next = reverse_weight + weight_shifted;
    end else begin
      forward_acc_next    = forward_acc;
      reverse_acc_next    = reverse_acc;
      reverse_weight_next = reverse_weight;
    end
  end

  // job for the back end on the closing transaction
  assign job_push = accept && last;
  always_comb begin
    job.rev = reverse_acc_next;
    job.fwd = forward_acc_next;
    job.id  = message_id;
  end

  // hash state, cleared again after each message
  always_ff @(posedge clk) begin
    if (rst || job_push) begin
      forward_acc    <= '0;
      reverse_acc    <= '0;
      reverse_weight <= 32'd1;
      index_odd      <= 1'b0;
    end else if (accept && byte_valid) begin
      forward_acc    <= forward_acc_next;
      reverse_acc    <= reverse_acc_next;
      reverse_weight <= reverse_weight_next;
      index_odd      <= ~index_odd;
    end
  end

endmodule

>>> rtl/ids_queue.sv
// two-entry job queue between front and back end
// depends on ids_pkg for the job type

module ids_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ids_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output ids_pkg::job_t pop_data,
  output logic          empty
);

  ids_pkg::job_t slots [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) wr_ptr <= ~wr_ptr;
      if (pop && !empty) rd_ptr <= ~rd_ptr;
      if ((push && !full) && !(pop && !empty)) begin
        count <= count + 2'd1;
      end else if (!(push && !full) && (pop && !empty)) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

>>> rtl/ids_back.sv
// back end: mixes the id with both hashes and multiplies out the code
// depends on ids_pkg; one 32x32 multiplier in each of S_MUL1 and S_MUL2, result register at the end

module ids_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_valid,
  input  ids_pkg::job_t       job,
  output logic                job_pop,
  input  logic                pop,
  output logic                empty,
  output logic signed [31:0]  url_code
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2
  } state_t;

  state_t      state;
  logic [31:0] sum_term;
  logic [31:0] fe_term;
  logic [31:0] ri_term;
  logic [31:0] partial;
  logic        out_valid;
  logic [31:0] eid;
  logic        out_free;

  assign eid      = ids_pkg::mix_id(job.id);
  assign job_pop  = (state == S_IDLE) && job_valid;
  assign empty    = !out_valid;
  assign out_free = !out_valid || pop;

  // sequencer, operand registers and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // result register fills from the last stage and drains on pop
      out_valid <= ((state == S_MUL2) && out_free) || (out_valid && !pop);
      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            sum_term <= (job.rev ^ eid) + (job.fwd | job.id);
            fe_term  <= job.fwd | eid;
            ri_term  <= job.rev ^ job.id;
            state    <= S_MUL1;
          end
        end
        S_MUL1: begin
          partial <= sum_term * fe_term;
          state   <= S_MUL2;
        end
        S_MUL2: begin
          if (out_free) begin
            url_code <= partial * ri_term;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/id_string_keyed_hash.sv
// Keyed hash of a byte message and a 32-bit record id, one signed code per message.
// Input channel (push/full): one transaction per byte; byte_valid low carries no byte,
// last marks the closing transaction, whose message_id is used for the code.
// Result channel (empty/pop): url_code is valid while empty is low and leaves on pop.
// Throughput: the front end takes one transaction per cycle while full is low; both
// hashes update in the same cycle with an 8x32 multiply and shift-adds.
// A job passes the queue slot, the operand registers, partial and then url_code; the
// back end takes no new job until its two chained 32x32 multiplies are done, so with
// a two-entry job queue the sustained rate is set by the message length or back end.
// Stall: if pop stays low the code holds, the back end waits, the job queue fills and
// full rises, stopping input until the result is taken.
// Reset (rst, synchronous): hashes, queue and result valid flag clear; empty high,
// full low the cycle after.
// Depends on ids_pkg, ids_front, ids_queue, ids_back.

module id_string_keyed_hash (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [7:0]          data_byte,
  input  logic                byte_valid,
  input  logic signed [31:0]  message_id,
  input  logic                last,
  output logic                empty,
  input  logic                pop,
  output logic signed [31:0]  url_code
);

  logic          accept;
  logic          job_push;
  ids_pkg::job_t job_in;
  ids_pkg::job_t job_out;
  logic          job_empty;
  logic          job_pop;

  assign accept = push && !full;

  // hashing front end
  ids_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .data_byte  (data_byte),
    .byte_valid (byte_valid),
    .message_id (message_id),
    .last       (last),
    .job_push   (job_push),
    .job        (job_in)
  );

  // jobs between the two halves
  ids_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .push_data (job_in),
    .full      (full),
    .pop       (job_pop),
    .pop_data  (job_out),
    .empty     (job_empty)
  );

  // code combining back end
  ids_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (!job_empty),
    .job       (job_out),
    .job_pop   (job_pop),
    .pop       (pop),
    .empty     (empty),
    .url_code  (url_code)
  );

endmodule

>>> rtl/ids_checker.sv
// port-level checks for id_string_keyed_hash
// depends only on the top-level ports; attached by the bind below

module ids_checker (
  input logic        clk,
  input logic        rst,
  input logic        push,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [31:0] url_code
);

  // a waiting result stays put until taken
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(url_code)))
    else $error("result changed or vanished while stalled");

  // empty stays high after reset, as the back end restarts in S_IDLE with no result
  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty ##1 empty)
    else $error("result present too soon after reset");

  // the job queue is drained by reset
  a_reset_not_full: assert property (@(posedge clk)
    rst |=> !full)
    else $error("input blocked right after reset");

  // the queue only fills when a transaction comes in
  a_full_needs_push: assert property (@(posedge clk) disable iff (rst)
    (!full && !push) |=> !full)
    else $error("full rose with no input transaction");

endmodule

bind id_string_keyed_hash ids_checker u_ids_checker (
  .clk      (clk),
  .rst      (rst),
  .push     (push),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .url_code (url_code)
);
